>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the RSN capabilities extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every clock edge outside reset
`define ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked at every clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> design/rce_pkg.sv
// Shared types, constants and helpers for the RSN capabilities extractor.
package rce_pkg;

  localparam logic [7:0]  RSN_ID      = 8'h30;
  localparam logic [7:0]  RSN_MIN_LEN = 8'd10;
  localparam int          OFS_W       = 19;
  localparam logic [18:0] OFFSET_MAX  = 19'h7FFFF;

  // Element walk phase, one-hot
  typedef enum logic [3:0] {
    PH_ID   = 4'b0001,   // awaiting element id
    PH_LEN  = 4'b0010,   // awaiting element length
    PH_PRE  = 4'b0100,   // body, before the AKM count
    PH_POST = 4'b1000    // body, after the AKM count
  } phase_t;

  // One frame result
  typedef struct packed {
    logic [15:0] rsn_caps;
    logic        caps_found;
  } rce_result_t;

  // Clamp a 20-bit offset sum to the 19-bit offset range
  function automatic logic [18:0] sat_offset(input logic [19:0] v);
    logic [18:0] r;
    r = v[19] ? OFFSET_MAX : v[18:0];
    return r;
  endfunction

endpackage

>>> design/rce_intf.sv
// Valid/ready channel interfaces for frame bytes in and capability results out.
interface rce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface rce_caps_if;
  logic        valid;
  logic        ready;
  logic [15:0] rsn_caps;
  logic        caps_found;

  modport source (output valid, output rsn_caps, output caps_found, input ready);
  modport sink   (input valid, input rsn_caps, input caps_found, output ready);
endinterface

>>> design/rce_walker.sv
// Information element walker: per-byte parse state and the frame result.
module rce_walker
  import rce_pkg::*;
#(
  parameter int HEADER_BYTES = 36
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  output rce_result_t result
);

  localparam int HC_W = $clog2(HEADER_BYTES + 1);

  logic [HC_W-1:0]  header_count,   header_count_next;
  phase_t           phase,          phase_next;
  logic [7:0]       element_id,     element_id_next;
  logic [7:0]       element_length, element_length_next;
  logic [7:0]       body_index,     body_index_next;
  logic [7:0]       low_byte_hold,  low_byte_hold_next;
  logic [OFS_W-1:0] field_offset,   field_offset_next;
  logic [15:0]      candidate_caps, candidate_caps_next;
  logic             candidate_valid, candidate_valid_next;
  logic [15:0]      committed_caps, committed_caps_next;
  logic             walk_done,      walk_done_next;

  logic [15:0] word;
  logic [8:0]  idx_inc;
  logic        rsn;
  logic        lo_hit;
  logic        hi_hit;
  logic [19:0] first_off;
  logic [19:0] akm_off;

  // Field decode from the current byte and held state
  assign word      = {data_byte, low_byte_hold};
  assign idx_inc   = {1'b0, body_index} + 9'd1;
  assign rsn       = (element_id == RSN_ID) && (element_length >= RSN_MIN_LEN);
  assign lo_hit    = ({11'b0, body_index} == field_offset);
  assign hi_hit    = ({12'b0, body_index} == ({1'b0, field_offset} + 20'd1));
  assign first_off = 20'd8 + {2'b0, word, 2'b0};
  assign akm_off   = {1'b0, field_offset} + 20'd2 + {2'b0, word, 2'b0};

  // Next state for one transfer
  always_comb begin
    header_count_next    = header_count;
    phase_next           = phase;
    element_id_next      = element_id;
    element_length_next  = element_length;
    body_index_next      = body_index;
    low_byte_hold_next   = low_byte_hold;
    field_offset_next    = field_offset;
    candidate_caps_next  = candidate_caps;
    candidate_valid_next = candidate_valid;
    committed_caps_next  = committed_caps;
    walk_done_next       = walk_done;
    result               = '0;

    if (take) begin
      if (header_count < HC_W'(HEADER_BYTES)) begin
        header_count_next = header_count + HC_W'(1);
      end else if (!walk_done) begin
        unique case (phase)
          PH_ID: begin
            element_id_next = data_byte;
            phase_next      = PH_LEN;
          end
          PH_LEN: begin
            element_length_next  = data_byte;
            body_index_next      = '0;
            field_offset_next    = '0;
            candidate_valid_next = 1'b0;
            phase_next           = PH_PRE;
            if (data_byte == 8'd0) begin
              phase_next = PH_ID;
            end
          end
          PH_PRE, PH_POST: begin
            if (rsn) begin
              priority if (body_index == 8'd6) begin
                low_byte_hold_next = data_byte;
              end else if (body_index == 8'd7) begin
                field_offset_next = sat_offset(first_off);
              end else if (body_index >= 8'd8 && lo_hit) begin
                low_byte_hold_next = data_byte;
              end else if (body_index >= 8'd8 && hi_hit) begin
                if (phase == PH_PRE) begin
                  field_offset_next = sat_offset(akm_off);
                  phase_next        = PH_POST;
                end else begin
                  candidate_caps_next  = word;
                  candidate_valid_next = 1'b1;
                end
              end
            end
            body_index_next = idx_inc[7:0];
            // End of element: if a complete word was read, commit it and stop the walk
            if (idx_inc >= {1'b0, element_length}) begin
              if (candidate_valid_next) begin
                committed_caps_next = candidate_caps_next;
                walk_done_next      = 1'b1;
              end
              candidate_valid_next = 1'b0;
              phase_next           = PH_ID;
            end
          end
          default: begin
            phase_next = PH_ID;
          end
        endcase
      end

      // Last byte: report and start over for the next frame
      if (frame_last) begin
        result.rsn_caps      = walk_done_next ? committed_caps_next : 16'd0;
        result.caps_found    = walk_done_next;
        header_count_next    = '0;
        phase_next           = PH_ID;
        element_id_next      = '0;
        element_length_next  = '0;
        body_index_next      = '0;
        low_byte_hold_next   = '0;
        field_offset_next    = '0;
        candidate_caps_next  = '0;
        candidate_valid_next = 1'b0;
        committed_caps_next  = '0;
        walk_done_next       = 1'b0;
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      phase           <= PH_ID;
      element_id      <= '0;
      element_length  <= '0;
      body_index      <= '0;
      low_byte_hold   <= '0;
      field_offset    <= '0;
      candidate_caps  <= '0;
      candidate_valid <= 1'b0;
      committed_caps  <= '0;
      walk_done       <= 1'b0;
    end else begin
      header_count    <= header_count_next;
      phase           <= phase_next;
      element_id      <= element_id_next;
      element_length  <= element_length_next;
      body_index      <= body_index_next;
      low_byte_hold   <= low_byte_hold_next;
      field_offset    <= field_offset_next;
      candidate_caps  <= candidate_caps_next;
      candidate_valid <= candidate_valid_next;
      committed_caps  <= committed_caps_next;
      walk_done       <= walk_done_next;
    end
  end

endmodule

>>> design/rsn_capabilities_extractor.sv
// Top level of the RSN capabilities extractor: byte walker plus result register.
//
//   channel    dir  payload                       transfer
//   byte_in    in   data_byte[7:0], frame_last    valid && ready
//   caps_out   out  rsn_caps[15:0], caps_found    valid && ready, one per frame
//
// One byte per cycle while byte_in is not stalled; the result shows in the cycle after the last byte's transfer.
// The walker state updates in the cycle of each byte transfer; the result
// register is the only pipeline stage.
// byte_in stalls only while a result waits in the register and caps_out is not ready.
// Synchronous reset clears the walk state and empties the result register.
module rsn_capabilities_extractor
  import rce_pkg::*;
#(
  parameter int HEADER_BYTES = 36
) (
  input  logic       clk,
  input  logic       rst,
  rce_byte_if.sink   byte_in,
  rce_caps_if.source caps_out
);

`include "assert_macros.svh"

  logic        in_fire;
  logic        out_fire;
  rce_result_t walk_result;
  rce_result_t result_reg;
  logic        result_valid;

  assign byte_in.ready = !result_valid || caps_out.ready;
  assign in_fire       = byte_in.valid && byte_in.ready;
  assign out_fire      = result_valid && caps_out.ready;

  rce_walker #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .take       (in_fire),
    .data_byte  (byte_in.data_byte),
    .frame_last (byte_in.frame_last),
    .result     (walk_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_fire && byte_in.frame_last) begin
      result_valid <= 1'b1;
    end else if (out_fire) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && byte_in.frame_last) begin
      result_reg <= walk_result;
    end
  end

  assign caps_out.valid      = result_valid;
  assign caps_out.rsn_caps   = result_reg.rsn_caps;
  assign caps_out.caps_found = result_reg.caps_found;

  // Checks
  `ASSERT_SAME(a_caps_zero, clk, rst, result_valid && !result_reg.caps_found, result_reg.rsn_caps == 16'd0, "rsn_caps nonzero without caps_found")
  `ASSERT_NEXT(a_last_gives_result, clk, rst, in_fire && byte_in.frame_last, result_valid, "no result after last byte")
  `ASSERT_NEXT(a_no_spurious, clk, rst, in_fire && !byte_in.frame_last && (!result_valid || caps_out.ready), !result_valid, "result without last byte")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the RSN capabilities extractor: frame stimulus and result check.
module tb;
  import rce_pkg::*;

  localparam int HDR_LEN   = 36;
  localparam int MAX_CYCLE = 400000;

  typedef logic [7:0] frame_bytes_t[$];

  logic clk;
  logic rst;

  rce_byte_if byte_ch();
  rce_caps_if caps_ch();

  rsn_capabilities_extractor #(
    .HEADER_BYTES(HDR_LEN)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .caps_out(caps_ch)
  );

  // Expected per-frame results, oldest first
  rce_result_t caps_expected[$];
  frame_bytes_t frame_buf;

  int errors;
  int send_gap_max;
  int recv_gap_max;
  int hold_left;
  int items_sent;

  // Element walker mirror
  int          skip_cnt;
  phase_t      walk_phase;
  logic [7:0]  ie_id;
  logic [7:0]  ie_len;
  int          ie_idx;
  logic [7:0]  lo_hold;
  int          next_ofs;
  logic [15:0] cand_caps;
  bit          cand_ok;
  logic [15:0] kept_caps;
  bit          have_caps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    repeat (MAX_CYCLE) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40)
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  function automatic int ofs_clamp(input int v);
    return (v > int'(OFFSET_MAX)) ? int'(OFFSET_MAX) : v;
  endfunction

  // Append one byte to the frame under construction
  task automatic add_byte(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endtask

  task automatic clear_walk();
    skip_cnt   = 0;
    walk_phase = PH_ID;
    ie_id      = '0;
    ie_len     = '0;
    ie_idx     = 0;
    lo_hold    = '0;
    next_ofs   = 0;
    cand_caps  = '0;
    cand_ok    = 1'b0;
    kept_caps  = '0;
    have_caps  = 1'b0;
  endtask

  // End of an element: a word read from it becomes the frame's word
  task automatic close_element();
    if (cand_ok) begin
      kept_caps = cand_caps;
      have_caps = 1'b1;
    end
    cand_ok    = 1'b0;
    walk_phase = PH_ID;
  endtask

  // Advance the walker by one accepted byte; queue the result on the last byte
  task automatic walk_byte(input logic [7:0] b, input logic last);
    rce_result_t r;
    int          idx;
    int          word;
    bit          is_rsn;
    if (skip_cnt < HDR_LEN) begin
      skip_cnt++;
    end else if (!have_caps) begin
      case (walk_phase)
        PH_ID: begin
          ie_id      = b;
          walk_phase = PH_LEN;
        end
        PH_LEN: begin
          ie_len     = b;
          ie_idx     = 0;
          next_ofs   = 0;
          cand_ok    = 1'b0;
          walk_phase = PH_PRE;
          if (ie_len == 0) close_element();
        end
        default: begin
          idx    = ie_idx;
          is_rsn = (ie_id == RSN_ID) && (ie_len >= RSN_MIN_LEN);
          if (is_rsn) begin
            if (idx == 6) begin
              lo_hold = b;
            end else if (idx == 7) begin
              word     = {b, lo_hold};
              next_ofs = ofs_clamp(8 + 4 * word);
            end else if (idx >= 8 && idx == next_ofs) begin
              lo_hold = b;
            end else if (idx >= 8 && idx == next_ofs + 1) begin
              word = {b, lo_hold};
              if (walk_phase == PH_PRE) begin
                next_ofs   = ofs_clamp(next_ofs + 2 + 4 * word);
                walk_phase = PH_POST;
              end else begin
                cand_caps = word[15:0];
                cand_ok   = 1'b1;
              end
            end
          end
          ie_idx = (idx + 1) & 255;
          if (idx + 1 >= ie_len) close_element();
        end
      endcase
    end
    if (last) begin
      r.rsn_caps   = have_caps ? kept_caps : 16'h0000;
      r.caps_found = have_caps;
      caps_expected.insert(caps_expected.size(), r);
      clear_walk();
    end
  endtask

  // One byte transfer; valid stays high afterwards for a back-to-back byte
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk);
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.frame_last <= last;
    do @(posedge clk); while (!byte_ch.ready);
    items_sent++;
    walk_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  task automatic hold_input();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
  endtask

  // Stop offering bytes until every queued result has come out
  task automatic drain_results();
    hold_input();
    while (caps_expected.size() != 0) @(posedge clk);
  endtask

  // Frame building blocks
  task automatic put_header();
    repeat (HDR_LEN) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_ie(input logic [7:0] id, input int len);
    add_byte(id);
    add_byte(len[7:0]);
    repeat (len) add_byte(8'($urandom_range(0, 255)));
  endtask

  // RSN element with the given counts and word, cut or padded to len body bytes
  task automatic put_rsn(input logic [15:0] p, input logic [15:0] m,
                         input logic [15:0] caps, input int len);
    int akm_ofs;
    int cap_ofs;
    akm_ofs = 8 + 4 * p;
    cap_ofs = akm_ofs + 2 + 4 * m;
    add_byte(RSN_ID);
    add_byte(len[7:0]);
    for (int idx = 0; idx < len; idx++) begin
      if (idx == 6)                add_byte(p[7:0]);
      else if (idx == 7)           add_byte(p[15:8]);
      else if (idx == akm_ofs)     add_byte(m[7:0]);
      else if (idx == akm_ofs + 1) add_byte(m[15:8]);
      else if (idx == cap_ofs)     add_byte(caps[7:0]);
      else if (idx == cap_ofs + 1) add_byte(caps[15:8]);
      else                         add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Random frame: mostly well-formed element walks, some noise and cut frames
  task automatic build_random_frame();
    int n_el;
    int kind;
    int p;
    int m;
    int full;
    int cut;
    put_header();
    n_el = $urandom_range(0, 4);
    repeat (n_el) begin
      kind = $urandom_range(0, 9);
      p    = $urandom_range(0, 2);
      m    = $urandom_range(0, 2);
      full = 12 + 4 * p + 4 * m;
      if (kind <= 4)
        put_rsn(16'(p), 16'(m), 16'($urandom_range(0, 65535)),
                full + $urandom_range(0, 3));
      else if (kind == 5)
        put_rsn(16'(p), 16'(m), 16'($urandom_range(0, 65535)),
                $urandom_range(0, full - 1));
      else if (kind == 6 && $urandom_range(0, 1) == 0)
        put_rsn(16'($urandom_range(64, 65535)), 16'(m), 16'($urandom_range(0, 65535)),
                $urandom_range(10, 60));
      else if (kind == 6)
        put_rsn(16'(p), 16'($urandom_range(64, 65535)), 16'($urandom_range(0, 65535)),
                $urandom_range(10, 60));
      else
        put_ie(8'($urandom_range(0, 255)), $urandom_range(0, 12));
    end
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(0, 255)));
    // Cut frames end at a random byte, which can fall inside the header or inside an element
    if ($urandom_range(0, 9) < 2) begin
      cut = $urandom_range(1, frame_buf.size());
      while (frame_buf.size() > cut) frame_buf.delete(frame_buf.size() - 1);
    end
  endtask

  // Frames that end in the header, right after it, or after an id or length alone
  task automatic test_short_frames();
    add_byte(8'hFF);
    send_frame();
    repeat (HDR_LEN) add_byte(8'h00);
    send_frame();
    put_header();
    add_byte(RSN_ID);
    send_frame();
    put_header();
    add_byte(RSN_ID);
    add_byte(8'd20);
    send_frame();
  endtask

  task automatic test_rsn_found();
    put_header();
    put_rsn(16'd0, 16'd0, 16'hFFFF, 12);
    send_frame();
    put_header();
    put_ie(8'h00, 0);
    put_rsn(16'd2, 16'd1, 16'h0000, 24);
    put_ie(8'hDD, 4);
    send_frame();
    put_header();
    put_ie(8'hDD, 20);
    put_rsn(16'd1, 16'd1, 16'hA55A, 255);
    send_frame();
  endtask

  // RSN elements too short for the word are skipped
  task automatic test_short_rsn();
    put_header();
    put_rsn(16'd0, 16'd0, 16'h1234, 10);
    put_rsn(16'd1, 16'd0, 16'h2345, 11);
    put_rsn(16'd0, 16'd0, 16'h3456, 9);
    put_rsn(16'd0, 16'd0, 16'hBEEF, 12);
    send_frame();
  endtask

  // Frame ends inside the element that holds the word
  task automatic test_overrun();
    put_header();
    put_rsn(16'd0, 16'd0, 16'hCAFE, 14);
    frame_buf.delete(frame_buf.size() - 1);
    send_frame();
    put_header();
    put_rsn(16'd1, 16'd1, 16'h5A5A, 20);
    frame_buf.delete(frame_buf.size() - 1);
    frame_buf.delete(frame_buf.size() - 1);
    send_frame();
  endtask

  // Bytes after the first complete word are ignored
  task automatic test_after_word();
    put_header();
    put_rsn(16'd1, 16'd2, 16'h0F0F, 24);
    put_rsn(16'd0, 16'd0, 16'hF0F0, 12);
    repeat (40) add_byte(8'($urandom_range(0, 255)));
    send_frame();
  endtask

  task automatic test_huge_counts();
    put_header();
    put_rsn(16'hFFFF, 16'd0, 16'h1111, 40);
    put_rsn(16'd0, 16'hFFFF, 16'h2222, 60);
    put_rsn(16'd0, 16'd0, 16'h7777, 12);
    send_frame();
  endtask

  // Receiver holds off while short frames keep coming, so the input stalls
  task automatic test_backpressure();
    send_gap_max = 0;
    hold_left    = 300;
    repeat (6) begin
      put_header();
      put_rsn(16'd0, 16'd0, 16'($urandom_range(0, 65535)), 12);
      send_frame();
    end
    drain_results();
    send_gap_max = 8;
  endtask

  // Random frames until the run has sent its share of bytes
  task automatic test_random();
    int frames;
    frames = 0;
    while (items_sent < 1600 || frames < 8) begin
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      build_random_frame();
      send_frame();
      frames++;
      if (frames % 4 == 0) drain_results();
    end
  endtask

  // Receiver: random ready gaps, plus a long hold when requested
  initial begin
    int gap;
    caps_ch.ready = 1'b0;
    forever begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, recv_gap_max);
      repeat (gap) begin
        @(negedge clk);
        caps_ch.ready <= 1'b0;
      end
      while (hold_left > 0) begin
        @(negedge clk);
        caps_ch.ready <= 1'b0;
        hold_left--;
      end
      @(negedge clk);
      caps_ch.ready <= 1'b1;
      do @(posedge clk); while (!caps_ch.valid);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    rce_result_t want;
    if (!rst && caps_ch.valid && caps_ch.ready) begin
      if (caps_expected.size() == 0) begin
        report_mismatch("result with none expected", caps_ch.rsn_caps, 0);
      end else begin
        want = caps_expected.pop_front();
        if (caps_ch.rsn_caps !== want.rsn_caps)
          report_mismatch("rsn_caps", caps_ch.rsn_caps, want.rsn_caps);
        if (caps_ch.caps_found !== want.caps_found)
          report_mismatch("caps_found", caps_ch.caps_found, want.caps_found);
      end
    end
  end

  initial begin
    errors             = 0;
    send_gap_max       = 8;
    recv_gap_max       = 8;
    hold_left          = 0;
    items_sent         = 0;
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = 8'h00;
    byte_ch.frame_last = 1'b0;
    clear_walk();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_short_frames();
    test_rsn_found();
    test_short_rsn();
    test_overrun();
    test_after_word();
    test_huge_counts();
    test_backpressure();
    test_random();

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && caps_expected.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/rce_pkg.sv
design/rce_intf.sv
design/rce_walker.sv
design/rsn_capabilities_extractor.sv
tb/tb.sv
